FILE: design/kmct_pkg.sv
// ----------------------------------------------------------------------------
// kmct_pkg: shared types and constants of the multi-click key tracker.
// Holds the request and response payloads and the modifier key codes.
// ----------------------------------------------------------------------------
package kmct_pkg;

  // Key space and field widths.
  localparam int unsigned KeyBits    = 8;
  localparam int unsigned NumKeys    = 256;
  localparam int unsigned ThrBits    = 31;
  localparam int unsigned TimeFieldW = 32;
  localparam int unsigned CountOutW  = 8;
  localparam int unsigned NumMods    = 9;

  // Threshold after reset, in milliseconds.
  localparam logic [ThrBits-1:0] ThrReset = 31'd300;

  // Modifier key codes: Ctrl group, then Shift group, then Alt group.
  localparam logic [KeyBits-1:0] ModKeys [NumMods] = '{
    8'h11, 8'hA2, 8'hA3,
    8'h10, 8'hA0, 8'hA1,
    8'h12, 8'hA4, 8'hA5
  };

  // Operation carried by a request.
  typedef enum logic {
    ACT_SAMPLE = 1'b0,
    ACT_CHECK  = 1'b1
  } kmct_action_e;

  // Input request payload.
  typedef struct packed {
    kmct_action_e            action;
    logic [KeyBits-1:0]      key_index;
    logic                    key_down;
    logic [TimeFieldW-1:0]   time_ms;
    logic [CountOutW-1:0]    target_combo;
    logic                    pack_usable;
    logic                    need_ctrl;
    logic                    need_shift;
    logic                    need_alt;
  } kmct_req_t;

  // Result payload.
  typedef struct packed {
    logic                    pressed;
    logic [CountOutW-1:0]    live_count;
    logic [CountOutW-1:0]    buffered_count;
    logic                    matched;
  } kmct_rsp_t;

endpackage

FILE: design/kmct_ram.sv
// ----------------------------------------------------------------------------
// kmct_ram: generic single-port-write, single-port-read RAM.
// One write and one registered read per cycle; a read of the address being
// written returns the old contents.
// ----------------------------------------------------------------------------
module kmct_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/kmct_update.sv
// ----------------------------------------------------------------------------
// kmct_update: per-key update of the multi-click tracker.
// Takes one key entry and the modifier levels, applies a sample or a check
// request and returns the new entry, the new levels and the response.
// ----------------------------------------------------------------------------
module kmct_update #(
  parameter int unsigned TimeBits  = 32,
  parameter int unsigned CountBits = 8,
  parameter int unsigned EntryW    = 1 + 2 * CountBits + TimeBits
) (
  input  kmct_pkg::kmct_req_t            req_i,
  input  logic [EntryW-1:0]              entry_i,
  input  logic [kmct_pkg::NumMods-1:0]   mods_i,
  input  logic [kmct_pkg::ThrBits-1:0]   thr_i,
  output logic [EntryW-1:0]              entry_o,
  output logic [kmct_pkg::NumMods-1:0]   mods_o,
  output kmct_pkg::kmct_rsp_t            rsp_o
);

  import kmct_pkg::*;

  typedef struct packed {
    logic                 held;
    logic [CountBits-1:0] live;
    logic [CountBits-1:0] buffered;
    logic [TimeBits-1:0]  stamp;
  } entry_t;

  entry_t               cur;
  entry_t               nxt;
  logic [TimeBits-1:0]  now;
  logic [TimeBits-1:0]  elapsed;
  logic [TimeBits-1:0]  thr_one;
  logic [TimeBits-1:0]  thr_two;
  logic                 grp_ctrl;
  logic                 grp_shift;
  logic                 grp_alt;
  logic                 hit;

  assign cur = entry_t'(entry_i);

  // Time and thresholds reduced to the stamp width.
  assign now     = TimeBits'(req_i.time_ms);
  assign elapsed = now - cur.stamp;
  assign thr_one = TimeBits'(thr_i);
  assign thr_two = TimeBits'({thr_i, 1'b0});

  // Modifier groups as they stand before this request.
  assign grp_ctrl  = |mods_i[2:0];
  assign grp_shift = |mods_i[5:3];
  assign grp_alt   = |mods_i[8:6];

  // A check succeeds on a usable pack, exact modifiers and a matching buffer.
  assign hit = req_i.pack_usable &&
               (req_i.need_ctrl == grp_ctrl) &&
               (req_i.need_shift == grp_shift) &&
               (req_i.need_alt == grp_alt) &&
               (16'(cur.buffered) == 16'(req_i.target_combo));

  // Entry update.
  always_comb begin
    nxt = cur;
    if (req_i.action == ACT_SAMPLE) begin
      // Expire the buffer, then close a run that has gone quiet.
      if ((cur.buffered != '0) && (elapsed > thr_two)) begin
        nxt.buffered = '0;
      end
      if ((cur.live != '0) && (elapsed > thr_one)) begin
        nxt.buffered = cur.live;
        nxt.live     = '0;
      end
      // Count a rising edge and restamp while held.
      if (req_i.key_down) begin
        if (!cur.held) begin
          nxt.live = nxt.live + CountBits'(1);
        end
        nxt.stamp = now;
      end
      nxt.held = req_i.key_down;
    end else if (hit) begin
      nxt.buffered = '0;
    end
  end

  // Mirror the level of a sampled modifier key.
  always_comb begin
    mods_o = mods_i;
    if (req_i.action == ACT_SAMPLE) begin
      for (int i = 0; i < NumMods; i++) begin
        if (req_i.key_index == ModKeys[i]) begin
          mods_o[i] = req_i.key_down;
        end
      end
    end
  end

  assign entry_o = EntryW'(nxt);

  // Response fields come from the updated entry.
  assign rsp_o.pressed        = nxt.held;
  assign rsp_o.live_count     = CountOutW'(nxt.live);
  assign rsp_o.buffered_count = CountOutW'(nxt.buffered);
  assign rsp_o.matched        = (req_i.action == ACT_CHECK) && hit;

endmodule

FILE: design/key_multi_click_tracker.sv
// ----------------------------------------------------------------------------
// key_multi_click_tracker: multi-click detector for 256 keys, table in RAM.
// A request accepted into the update stage reaches out_valid_o once the output
// register is free; a stalled result holds the update stage.
// Throughput: one request per cycle unless stalled; the key table RAM does one
// read and one write each cycle; a back-to-back same-key update is forwarded.
// Reset clears every key through per-entry valid bits, with no clearing pass.
// ----------------------------------------------------------------------------
module key_multi_click_tracker #(
  parameter int unsigned TimeBits  = 32,
  parameter int unsigned CountBits = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [kmct_pkg::ThrBits-1:0]  cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  kmct_pkg::kmct_req_t           in_req_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output kmct_pkg::kmct_rsp_t           out_rsp_o
);

  import kmct_pkg::*;

  localparam int unsigned EntryW = 1 + 2 * CountBits + TimeBits;

  logic [ThrBits-1:0]  thr_q;
  logic [NumMods-1:0]  mods_q;
  logic [NumMods-1:0]  mods_d;
  logic [NumKeys-1:0]  valid_q;

  logic                s1_valid_q;
  kmct_req_t           s1_req_q;
  logic                fwd_hit_q;
  logic [EntryW-1:0]   fwd_entry_q;
  logic                rd_valid_q;

  logic                out_valid_q;
  kmct_rsp_t           out_rsp_q;

  logic                in_fire;
  logic                s1_fire;
  logic [EntryW-1:0]   ram_rdata;
  logic [EntryW-1:0]   s1_entry;
  logic [EntryW-1:0]   new_entry;
  kmct_rsp_t           new_rsp;

  // Handshake: the update stage moves when the output register is free.
  assign s1_fire    = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !s1_fire;
  assign in_fire    = in_valid_i && !in_stall_o;

  // Threshold register; a zero write is ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= ThrReset;
    end else if (cfg_we_i && (cfg_wdata_i != '0)) begin
      thr_q <= cfg_wdata_i;
    end
  end

  // Key table storage.
  kmct_ram #(
    .Width (EntryW),
    .Depth (NumKeys)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (s1_fire),
    .waddr_i (s1_req_q.key_index),
    .wdata_i (new_entry),
    .re_i    (in_fire),
    .raddr_i (in_req_i.key_index),
    .rdata_o (ram_rdata)
  );

  // Entry seen by the update stage: forwarded, stored or reset value.
  always_comb begin
    if (fwd_hit_q) begin
      s1_entry = fwd_entry_q;
    end else if (rd_valid_q) begin
      s1_entry = ram_rdata;
    end else begin
      s1_entry = '0;
    end
  end

  // Read-modify-write logic.
  kmct_update #(
    .TimeBits  (TimeBits),
    .CountBits (CountBits),
    .EntryW    (EntryW)
  ) u_update (
    .req_i   (s1_req_q),
    .entry_i (s1_entry),
    .mods_i  (mods_q),
    .thr_i   (thr_q),
    .entry_o (new_entry),
    .mods_o  (mods_d),
    .rsp_o   (new_rsp)
  );

  // Control state: stage valid, entry valid bits and modifier levels.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      fwd_hit_q  <= 1'b0;
      rd_valid_q <= 1'b0;
      valid_q    <= '0;
      mods_q     <= '0;
    end else begin
      if (in_fire) begin
        s1_valid_q <= 1'b1;
        fwd_hit_q  <= s1_fire && (s1_req_q.key_index == in_req_i.key_index);
        rd_valid_q <= valid_q[in_req_i.key_index];
      end else if (s1_fire) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_fire) begin
        valid_q[s1_req_q.key_index] <= 1'b1;
        mods_q                      <= mods_d;
      end
    end
  end

  // Request payload and forwarded entry of the update stage.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_req_q    <= in_req_i;
      fwd_entry_q <= new_entry;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_fire) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      out_rsp_q <= new_rsp;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

endmodule

FILE: test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking testbench of the multi-click key tracker.
// Requests come from a queue that a stimulus process fills phase by phase. A
// clocked driver sends them with random gaps, and a clocked monitor predicts
// each accepted request and checks every result against the oldest prediction.
// The output side is stalled at random, and the threshold is rewritten between
// phases while the block is idle.
// ----------------------------------------------------------------------------
module tb;
  import kmct_pkg::*;

  // Index of the copy of the key state: the monitor's copy follows accepted
  // requests, the planning copy follows generated ones.
  localparam int TrackSb   = 0;
  localparam int TrackPlan = 1;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                cfg_we_i    = 1'b0;
  logic [ThrBits-1:0]  cfg_wdata_i = '0;
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  kmct_req_t           in_req_i    = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  kmct_rsp_t           out_rsp_o;

  // Key state of the predictor, one copy per index above.
  logic                key_held  [2][NumKeys];
  logic [7:0]          key_live  [2][NumKeys];
  logic [7:0]          key_buf   [2][NumKeys];
  logic [31:0]         key_stamp [2][NumKeys];
  logic [NumMods-1:0]  mod_level [2];
  logic [ThrBits-1:0]  thr_ms    [2];

  kmct_req_t           key_event_q [$];
  kmct_rsp_t           predicted_report_q [$];
  logic                req_fire      = 1'b0;
  logic                idle_on       = 1'b1;
  int unsigned         gap_left      = 0;
  int unsigned         stall_left    = 0;
  int unsigned         error_count   = 0;
  int unsigned         planned_items = 0;
  logic [31:0]         now_ms        = '0;

  key_multi_click_tracker i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_rsp_o   (out_rsp_o)
  );

  // Free-running clock.
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Overall time limit.
  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // ------------------------------------------------------------------------
  // Predictor
  // ------------------------------------------------------------------------

  // Clears one copy of the key state to its reset values.
  function automatic void clear_tracker(input int s);
    int i;
    for (i = 0; i < NumKeys; i++) begin
      key_held[s][i]  = 1'b0;
      key_live[s][i]  = '0;
      key_buf[s][i]   = '0;
      key_stamp[s][i] = '0;
    end
    mod_level[s] = '0;
    thr_ms[s]    = ThrReset;
  endfunction

  // A write of zero leaves the threshold as it was.
  function automatic void set_threshold(input int s, input logic [ThrBits-1:0] v);
    if (v != '0) thr_ms[s] = v;
  endfunction

  // Held state of the Alt, Shift and Ctrl groups, Ctrl in bit 0.
  function automatic logic [2:0] group_levels(input int s);
    return {|mod_level[s][8:6], |mod_level[s][5:3], |mod_level[s][2:0]};
  endfunction

  // Applies one request to a copy of the key state and returns its report.
  function automatic kmct_rsp_t track_key_item(input int s, input kmct_req_t rq);
    kmct_rsp_t   rs;
    logic [7:0]  k;
    logic [31:0] elapsed;
    logic [31:0] lim_run;
    logic [31:0] lim_buf;
    logic [2:0]  grp;
    int          i;
    rs = '0;
    k  = rq.key_index;
    if (rq.action == ACT_SAMPLE) begin
      elapsed = rq.time_ms - key_stamp[s][k];
      lim_run = {1'b0, thr_ms[s]};
      lim_buf = {thr_ms[s], 1'b0};
      // An old buffered run expires first, then a stale live run is buffered.
      if (key_buf[s][k] != '0 && elapsed > lim_buf) key_buf[s][k] = '0;
      if (key_live[s][k] != '0 && elapsed > lim_run) begin
        key_buf[s][k]  = key_live[s][k];
        key_live[s][k] = '0;
      end
      if (rq.key_down) begin
        if (!key_held[s][k]) key_live[s][k] = key_live[s][k] + 8'd1;
        key_stamp[s][k] = rq.time_ms;
      end
      key_held[s][k] = rq.key_down;
      for (i = 0; i < NumMods; i++) begin
        if (ModKeys[i] == k) mod_level[s][i] = rq.key_down;
      end
    end else begin
      grp = group_levels(s);
      if (rq.pack_usable && rq.need_ctrl == grp[0] && rq.need_shift == grp[1] &&
          rq.need_alt == grp[2] && key_buf[s][k] == rq.target_combo) begin
        key_buf[s][k] = '0;
        rs.matched    = 1'b1;
      end
    end
    rs.pressed        = key_held[s][k];
    rs.live_count     = key_live[s][k];
    rs.buffered_count = key_buf[s][k];
    return rs;
  endfunction

  // ------------------------------------------------------------------------
  // Driver and monitor
  // ------------------------------------------------------------------------

  // Gap or stall length: most short, a few long, none while idling is off.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (!idle_on || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Sends queued requests and drives the output stall.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || req_fire) begin
        if (gap_left != 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (key_event_q.size() != 0) begin
          in_req_i   <= key_event_q.pop_front();
          in_valid_i <= 1'b1;
          gap_left   = pick_gap();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      if (stall_left != 0) begin
        stall_left--;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        out_stall_i <= 1'b1;
        stall_left  = pick_gap();
      end else begin
        out_stall_i <= 1'b0;
        stall_left  = $urandom_range(0, 6);
      end
    end
  end

  // Reports one field that differs from its prediction.
  task automatic report_field(input string name, input int unsigned expv,
                              input int unsigned actv);
    if (expv != actv) begin
      $display("%0t: mismatch in %s: expected %0d, actual %0d", $time, name, expv, actv);
      error_count++;
    end
  endtask

  // Predicts accepted requests and checks accepted results.
  always @(posedge clk_i) begin
    kmct_rsp_t exp_rsp;
    if (rst_ni) begin
      if (cfg_we_i) set_threshold(TrackSb, cfg_wdata_i);
      if (in_valid_i && !in_stall_o) begin
        predicted_report_q.push_back(track_key_item(TrackSb, in_req_i));
      end
      if (out_valid_o && !out_stall_i) begin
        if (predicted_report_q.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual %h", $time, out_rsp_o);
          error_count++;
        end else begin
          exp_rsp = predicted_report_q.pop_front();
          report_field("pressed", 32'(exp_rsp.pressed), 32'(out_rsp_o.pressed));
          report_field("live_count", 32'(exp_rsp.live_count),
                       32'(out_rsp_o.live_count));
          report_field("buffered_count", 32'(exp_rsp.buffered_count),
                       32'(out_rsp_o.buffered_count));
          report_field("matched", 32'(exp_rsp.matched), 32'(out_rsp_o.matched));
        end
      end
    end
    req_fire <= rst_ni && in_valid_i && !in_stall_o;
  end

  // ------------------------------------------------------------------------
  // Stimulus
  // ------------------------------------------------------------------------

  function automatic int unsigned cap(input int unsigned a, input int unsigned b);
    return (a < b) ? a : b;
  endfunction

  // Queues one request and follows it in the planning copy.
  function automatic void push_item(input kmct_req_t rq);
    void'(track_key_item(TrackPlan, rq));
    key_event_q.push_back(rq);
    planned_items++;
  endfunction

  // Sample request; the fields that a sample ignores carry random values.
  function automatic void sample_key(input logic [7:0] k, input logic down,
                                     input logic [31:0] t);
    kmct_req_t rq;
    rq              = '0;
    rq.action       = ACT_SAMPLE;
    rq.key_index    = k;
    rq.key_down     = down;
    rq.time_ms      = t;
    rq.target_combo = 8'($urandom_range(0, 255));
    rq.pack_usable  = 1'($urandom_range(0, 1));
    rq.need_ctrl    = 1'($urandom_range(0, 1));
    rq.need_shift   = 1'($urandom_range(0, 1));
    rq.need_alt     = 1'($urandom_range(0, 1));
    push_item(rq);
  endfunction

  // Check request; key_down and time_ms are ignored and so random.
  function automatic void check_key(input logic [7:0] k, input logic [7:0] target,
                                    input logic usable, input logic [2:0] needs);
    kmct_req_t rq;
    rq              = '0;
    rq.action       = ACT_CHECK;
    rq.key_index    = k;
    rq.key_down     = 1'($urandom_range(0, 1));
    rq.time_ms      = $urandom;
    rq.target_combo = target;
    rq.pack_usable  = usable;
    rq.need_ctrl    = needs[0];
    rq.need_shift   = needs[1];
    rq.need_alt     = needs[2];
    push_item(rq);
  endfunction

  // Time step that keeps a click run going.
  function automatic logic [31:0] step_ms();
    return $urandom_range(0, cap(32'(thr_ms[TrackPlan]), 40) / 2);
  endfunction

  // Time step that ends a click run without expiring its buffer.
  function automatic logic [31:0] run_gap_ms();
    return {1'b0, thr_ms[TrackPlan]} + 32'd1 +
           $urandom_range(0, cap(32'(thr_ms[TrackPlan]) - 32'd1, 500));
  endfunction

  // A run of clicks on one key, then a quiet sample that buffers the run.
  function automatic void click_run(input logic [7:0] k, input int unsigned n);
    int unsigned i;
    for (i = 0; i < n; i++) begin
      now_ms = now_ms + step_ms();
      sample_key(k, 1'b1, now_ms);
      now_ms = now_ms + step_ms();
      sample_key(k, 1'b0, now_ms);
    end
    now_ms = now_ms + run_gap_ms();
    sample_key(k, 1'b0, now_ms);
  endfunction

  // Check that should consume the buffer, or one that breaks a single condition.
  function automatic void combo_check(input logic [7:0] k, input logic spoil);
    logic [7:0] target;
    logic       usable;
    logic [2:0] needs;
    target = key_buf[TrackPlan][k];
    usable = 1'b1;
    needs  = group_levels(TrackPlan);
    if (spoil) begin
      case ($urandom_range(0, 4))
        0: begin
          target = target ^ 8'($urandom_range(1, 255));
        end
        1: begin
          usable = 1'b0;
        end
        default: begin
          needs[$urandom_range(0, 2)] ^= 1'b1;
        end
      endcase
    end
    check_key(k, target, usable, needs);
  endfunction

  // Fully random request.
  function automatic kmct_req_t random_item();
    kmct_req_t rq;
    rq.action       = kmct_action_e'($urandom_range(0, 1));
    rq.key_index    = 8'($urandom_range(0, 255));
    rq.key_down     = 1'($urandom_range(0, 1));
    rq.time_ms      = $urandom;
    rq.target_combo = 8'($urandom_range(0, 255));
    rq.pack_usable  = 1'($urandom_range(0, 1));
    rq.need_ctrl    = 1'($urandom_range(0, 1));
    rq.need_shift   = 1'($urandom_range(0, 1));
    rq.need_alt     = 1'($urandom_range(0, 1));
    return rq;
  endfunction

  // Mostly click runs with combo checks, with noise and expiries mixed in.
  task automatic random_phase(input int unsigned goal);
    int unsigned r;
    logic [7:0]  k;
    logic [7:0]  mod_k;
    logic        mod_held;
    int          i;
    planned_items = 0;
    while (planned_items < goal) begin
      r = $urandom_range(0, 99);
      if (r < 60) begin
        k = ($urandom_range(0, 3) == 0) ? ModKeys[$urandom_range(0, NumMods - 1)]
                                        : 8'($urandom_range(0, 255));
        mod_held = ($urandom_range(0, 9) < 4);
        mod_k    = ModKeys[$urandom_range(0, NumMods - 1)];
        if (mod_held) sample_key(mod_k, 1'b1, now_ms);
        click_run(k, $urandom_range(1, 4));
        combo_check(k, $urandom_range(0, 9) < 3);
        if (mod_held && $urandom_range(0, 1) == 1) sample_key(mod_k, 1'b0, now_ms);
      end else if (r < 80) begin
        push_item(random_item());
      end else if (r < 90) begin
        // Long silence so that the buffer of the key expires.
        k = 8'($urandom_range(0, 255));
        now_ms = now_ms + {thr_ms[TrackPlan], 1'b0} + 32'd1 + $urandom_range(0, 100);
        sample_key(k, 1'b0, now_ms);
        check_key(k, 8'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                  3'($urandom_range(0, 7)));
      end else begin
        // Release every modifier key.
        for (i = 0; i < NumMods; i++) sample_key(ModKeys[i], 1'b0, now_ms);
      end
    end
  endtask

  // Waits until every request has been sent and every result has arrived.
  task automatic wait_idle();
    while (key_event_q.size() != 0 || in_valid_i || predicted_report_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (4) @(posedge clk_i);
  endtask

  // Threshold write while the block is idle.
  task automatic write_threshold(input logic [ThrBits-1:0] v);
    wait_idle();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    set_threshold(TrackPlan, v);
  endtask

  // Reset, the directed part, then random phases under several thresholds.
  initial begin
    int unsigned cyc;
    clear_tracker(TrackSb);
    clear_tracker(TrackPlan);
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Check of an empty buffer with a zero target, and the field extremes.
    check_key(8'h00, 8'h00, 1'b1, 3'b000);
    check_key(8'hFF, 8'hFF, 1'b0, 3'b111);
    // Two clicks across the wrap of the millisecond time.
    sample_key(8'h41, 1'b1, 32'hFFFF_FFF0);
    sample_key(8'h41, 1'b0, 32'hFFFF_FFF8);
    sample_key(8'h41, 1'b1, 32'h0000_0004);
    sample_key(8'h41, 1'b1, 32'h0000_0010);
    sample_key(8'h41, 1'b0, 32'h0000_0020);
    check_key(8'h41, 8'd0, 1'b1, 3'b000);
    sample_key(8'h41, 1'b0, 32'h0000_013D);
    check_key(8'h41, 8'd2, 1'b0, 3'b000);
    // Ctrl held: the group must match exactly.
    sample_key(8'h11, 1'b1, 32'h0000_0140);
    check_key(8'h41, 8'd2, 1'b1, 3'b000);
    check_key(8'h41, 8'd2, 1'b1, 3'b001);
    sample_key(8'hA0, 1'b1, 32'h0000_0141);
    sample_key(8'hA5, 1'b1, 32'h0000_0142);
    check_key(8'hA5, 8'd0, 1'b1, 3'b111);
    sample_key(8'h11, 1'b0, 32'h0000_0150);
    sample_key(8'hA0, 1'b0, 32'h0000_0151);
    sample_key(8'hA5, 1'b0, 32'h0000_0152);
    // A buffered run that expires after twice the threshold.
    sample_key(8'hFF, 1'b1, 32'hFFFF_FFFF);
    sample_key(8'hFF, 1'b0, 32'h0000_0000);
    sample_key(8'hFF, 1'b0, 32'h0000_012D);
    sample_key(8'hFF, 1'b0, 32'h0000_0259);
    check_key(8'hFF, 8'd1, 1'b1, 3'b000);
    now_ms = 32'h0001_0000;

    random_phase(70);

    // Smallest threshold, with no idling on either side.
    write_threshold(31'd1);
    idle_on = 1'b0;
    random_phase(60);

    // Largest threshold, and a long run of clicks on one key.
    write_threshold(31'h7FFF_FFFF);
    idle_on = 1'b1;
    click_run(8'h5A, 20);
    combo_check(8'h5A, 1'b0);
    random_phase(50);

    // A zero write must leave the largest threshold in place.
    write_threshold(31'd0);
    random_phase(35);

    write_threshold(31'($urandom_range(2, 2000)));
    random_phase(70);

    write_threshold(31'd37);
    random_phase(60);

    // Drain, then give stray results time to arrive.
    cyc = 0;
    while ((key_event_q.size() != 0 || in_valid_i || predicted_report_q.size() != 0) &&
           cyc < 200000) begin
      @(posedge clk_i);
      cyc++;
    end
    repeat (10) @(posedge clk_i);
    if (predicted_report_q.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, predicted_report_q.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

FILE: sim.f
design/kmct_pkg.sv
design/kmct_ram.sv
design/kmct_update.sv
design/key_multi_click_tracker.sv
test/tb.sv
